### sv/ddacg_pkg.sv
// shared constants, types and the symmetry table of the dda circle generator
package ddacg_pkg;

    localparam int FRAC_BITS = 20;
    localparam int STEP_BITS = 24;
    localparam int POS_BITS  = 13 + FRAC_BITS;
    localparam int SUM_W     = POS_BITS + 2;
    localparam int MAG_W     = SUM_W - FRAC_BITS;
    localparam int CX_W      = 11;
    localparam int RAD_W     = 10;
    localparam int PIX_W     = 13;
    localparam int CNT_W     = $clog2(STEP_BITS + 1);
    localparam int PROD_W    = POS_BITS + STEP_BITS;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    localparam logic [2:0] SYM_LAST = 3'd7;

    localparam logic signed [POS_BITS-1:0] POS_MAX = {1'b0, {(POS_BITS - 1){1'b1}}};
    localparam logic signed [POS_BITS-1:0] POS_MIN = {1'b1, {(POS_BITS - 1){1'b0}}};

    localparam logic [MAG_W-1:0] PIX_POS_LIM = MAG_W'(4095);
    localparam logic [MAG_W-1:0] PIX_NEG_LIM = MAG_W'(4096);
    localparam logic signed [PIX_W-1:0] PIX_MAX = {1'b0, {(PIX_W - 1){1'b1}}};
    localparam logic signed [PIX_W-1:0] PIX_MIN = {1'b1, {(PIX_W - 1){1'b0}}};

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_MUL_X,
        S_UPD,
        S_EMIT,
        S_INVALID
    } t_state;

    typedef struct packed {
        logic load_start;
        logic store_inc;
        logic mul_y;
        logic mul_x;
        logic update;
        logic emit_point;
        logic emit_invalid;
    } t_cmd;

    typedef struct packed {
        logic div_busy;
        logic div_done;
        logic x_lt_y;
        logic idx_last;
        logic out_free;
    } t_stat;

    typedef struct packed {
        logic swap;
        logic neg_x;
        logic neg_y;
    } t_sym;

    // order (x,y) (y,x) (-x,y) (y,-x) (-x,-y) (-y,-x) (x,-y) (-y,x)
    function automatic t_sym sym_pattern(input logic [2:0] idx);
        t_sym s;
        unique case (idx)
            3'd0:    s = '{swap: 1'b0, neg_x: 1'b0, neg_y: 1'b0};
            3'd1:    s = '{swap: 1'b1, neg_x: 1'b0, neg_y: 1'b0};
            3'd2:    s = '{swap: 1'b0, neg_x: 1'b1, neg_y: 1'b0};
            3'd3:    s = '{swap: 1'b1, neg_x: 1'b0, neg_y: 1'b1};
            3'd4:    s = '{swap: 1'b0, neg_x: 1'b1, neg_y: 1'b1};
            3'd5:    s = '{swap: 1'b1, neg_x: 1'b1, neg_y: 1'b1};
            3'd6:    s = '{swap: 1'b0, neg_x: 1'b0, neg_y: 1'b1};
            default: s = '{swap: 1'b1, neg_x: 1'b1, neg_y: 1'b0};
        endcase
        return s;
    endfunction

endpackage

### sv/ddacg_div.sv
// restoring divider for the step increment, one quotient bit per cycle
module ddacg_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [ddacg_pkg::RAD_W-1:0]     i_divisor,
    output logic                            o_busy,
    output logic                            o_done,
    output logic [ddacg_pkg::STEP_BITS-1:0] o_quot
);

    logic [ddacg_pkg::RAD_W-1:0]     r_rem, n_rem;
    logic [ddacg_pkg::RAD_W-1:0]     r_d;
    logic [ddacg_pkg::STEP_BITS:0]   r_q, n_q;
    logic [ddacg_pkg::CNT_W-1:0]     r_cnt;
    logic                            r_busy;
    logic                            r_done;
    logic [ddacg_pkg::RAD_W:0]       trial;
    logic                            dbit;
    logic                            qbit;

    // the dividend is a single one at the top bit
    always_comb begin
        dbit  = (r_cnt == ddacg_pkg::CNT_W'(ddacg_pkg::STEP_BITS));
        trial = {r_rem, dbit};
        qbit  = (trial >= {1'b0, r_d});
        n_rem = qbit ? ddacg_pkg::RAD_W'(trial - {1'b0, r_d})
                     : ddacg_pkg::RAD_W'(trial);
        n_q   = {r_q[ddacg_pkg::STEP_BITS-1:0], qbit};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_q    <= '0;
            r_rem  <= '0;
            r_d    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= ddacg_pkg::CNT_W'(ddacg_pkg::STEP_BITS);
                r_q    <= '0;
                r_rem  <= '0;
                r_d    <= i_divisor;
            end else if (r_busy) begin
                r_q   <= n_q;
                r_rem <= n_rem;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    // radius one gives 2^STEP_BITS, which saturates
    assign o_quot = r_q[ddacg_pkg::STEP_BITS] ? {ddacg_pkg::STEP_BITS{1'b1}}
                                              : r_q[ddacg_pkg::STEP_BITS-1:0];

endmodule

### sv/ddacg_datapath.sv
// position registers, shared multiplier, point reflection and result register
module ddacg_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  ddacg_pkg::t_cmd                     i_cmd,
    output ddacg_pkg::t_stat                    o_stat,
    input  logic [ddacg_pkg::CX_W-1:0]          i_center_x,
    input  logic [ddacg_pkg::CX_W-1:0]          i_center_y,
    input  logic [ddacg_pkg::RAD_W-1:0]         i_radius,
    input  logic                                i_stall,
    output logic                                o_valid,
    output logic signed [ddacg_pkg::PIX_W-1:0]  o_point_x,
    output logic signed [ddacg_pkg::PIX_W-1:0]  o_point_y,
    output logic                                o_point_valid,
    output logic                                o_last,
    output logic                                o_finished
);

    localparam int PW = ddacg_pkg::POS_BITS;
    localparam int SW = ddacg_pkg::SUM_W;

    logic [ddacg_pkg::CX_W-1:0]       r_cx, r_cy;
    logic [ddacg_pkg::STEP_BITS-1:0]  r_inc;
    logic signed [PW-1:0]             r_pos_x, r_pos_y;
    logic [PW-1:0]                    r_my_mag, r_mx_mag;
    logic                             r_my_neg, r_mx_neg;
    logic [2:0]                       r_idx;

    logic                             r_o_valid;
    logic signed [ddacg_pkg::PIX_W-1:0] r_o_px, r_o_py;
    logic                             r_o_pv, r_o_last, r_o_fin;

    logic [ddacg_pkg::RAD_W-1:0]      rad_eff;
    logic                             div_busy, div_done;
    logic [ddacg_pkg::STEP_BITS-1:0]  div_quot;

    logic signed [PW-1:0]             mul_op;
    logic [PW-1:0]                    mul_mag;
    logic [ddacg_pkg::PROD_W-1:0]     mul_prod;
    logic [PW-1:0]                    mul_res;

    logic signed [SW-1:0]             x_sum, y_sum;
    logic signed [PW-1:0]             n_pos_x, n_pos_y;

    ddacg_pkg::t_sym                  sym;
    logic signed [PW-1:0]             src_x, src_y;
    logic signed [ddacg_pkg::PIX_W-1:0] pix_x, pix_y;
    logic                             out_free;

    function automatic logic signed [PW-1:0] sat_pos(input logic signed [SW-1:0] v);
        logic signed [PW-1:0] r;
        if (v > SW'(ddacg_pkg::POS_MAX)) begin
            r = ddacg_pkg::POS_MAX;
        end else if (v < SW'(ddacg_pkg::POS_MIN)) begin
            r = ddacg_pkg::POS_MIN;
        end else begin
            r = PW'(v);
        end
        return r;
    endfunction

    // centre + (+/-)offset, truncated toward zero, clamped to the pixel range
    function automatic logic signed [ddacg_pkg::PIX_W-1:0] to_pixel(
        input logic [ddacg_pkg::CX_W-1:0] c,
        input logic signed [PW-1:0]       v,
        input logic                       neg
    );
        logic signed [SW-1:0]        cfx;
        logic signed [SW-1:0]        ve;
        logic signed [SW-1:0]        s;
        logic [SW-1:0]               a;
        logic [ddacg_pkg::MAG_W-1:0] m;
        logic signed [ddacg_pkg::PIX_W-1:0] p;
        cfx = $signed({4'b0000, c, {ddacg_pkg::FRAC_BITS{1'b0}}});
        ve  = SW'(v);
        s   = neg ? (cfx - ve) : (cfx + ve);
        a   = s[SW-1] ? SW'(-s) : SW'(s);
        m   = a[SW-1:ddacg_pkg::FRAC_BITS];
        if (!s[SW-1]) begin
            p = (m > ddacg_pkg::PIX_POS_LIM) ? ddacg_pkg::PIX_MAX
                                             : $signed(ddacg_pkg::PIX_W'(m));
        end else begin
            p = (m > ddacg_pkg::PIX_NEG_LIM) ? ddacg_pkg::PIX_MIN
                                             : $signed(ddacg_pkg::PIX_W'(-m));
        end
        return p;
    endfunction

    assign rad_eff = (i_radius == '0) ? ddacg_pkg::RAD_W'(1) : i_radius;

    ddacg_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_cmd.load_start),
        .i_divisor (rad_eff),
        .o_busy    (div_busy),
        .o_done    (div_done),
        .o_quot    (div_quot)
    );

    // one multiplier, shared by the y*inc and x*inc products
    always_comb begin
        mul_op   = i_cmd.mul_x ? r_pos_x : r_pos_y;
        mul_mag  = mul_op[PW-1] ? PW'(-mul_op) : PW'(mul_op);
        mul_prod = {{ddacg_pkg::STEP_BITS{1'b0}}, mul_mag}
                 * {{PW{1'b0}}, r_inc};
        mul_res  = mul_prod[ddacg_pkg::PROD_W-1:ddacg_pkg::STEP_BITS];
    end

    // signs folded into one add or subtract each
    always_comb begin
        x_sum   = r_my_neg ? (SW'(r_pos_x) + $signed({2'b00, r_my_mag}))
                           : (SW'(r_pos_x) - $signed({2'b00, r_my_mag}));
        y_sum   = r_mx_neg ? (SW'(r_pos_y) - $signed({2'b00, r_mx_mag}))
                           : (SW'(r_pos_y) + $signed({2'b00, r_mx_mag}));
        n_pos_x = sat_pos(x_sum);
        n_pos_y = sat_pos(y_sum);
    end

    always_comb begin
        sym   = ddacg_pkg::sym_pattern(r_idx);
        src_x = sym.swap ? r_pos_y : r_pos_x;
        src_y = sym.swap ? r_pos_x : r_pos_y;
        pix_x = to_pixel(r_cx, src_x, sym.neg_x);
        pix_y = to_pixel(r_cy, src_y, sym.neg_y);
    end

    assign out_free = !r_o_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx    <= '0;
            r_cy    <= '0;
            r_inc   <= '0;
            r_pos_x <= '0;
            r_pos_y <= '0;
            r_idx   <= '0;
        end else begin
            if (i_cmd.load_start) begin
                r_cx    <= i_center_x;
                r_cy    <= i_center_y;
                r_pos_x <= $signed(PW'(rad_eff) << ddacg_pkg::FRAC_BITS);
                r_pos_y <= '0;
            end
            if (i_cmd.store_inc) begin
                r_inc <= div_quot;
            end
            if (i_cmd.update) begin
                r_pos_x <= n_pos_x;
                r_pos_y <= n_pos_y;
                r_idx   <= '0;
            end else if (i_cmd.emit_point) begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_y) begin
            r_my_mag <= mul_res;
            r_my_neg <= r_pos_y[PW-1];
        end
        if (i_cmd.mul_x) begin
            r_mx_mag <= mul_res;
            r_mx_neg <= r_pos_x[PW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.emit_point || i_cmd.emit_invalid) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_point) begin
            r_o_px   <= pix_x;
            r_o_py   <= pix_y;
            r_o_pv   <= 1'b1;
            r_o_last <= (r_idx == ddacg_pkg::SYM_LAST);
            r_o_fin  <= (r_pos_x < r_pos_y);
        end else if (i_cmd.emit_invalid) begin
            r_o_px   <= '0;
            r_o_py   <= '0;
            r_o_pv   <= 1'b0;
            r_o_last <= 1'b1;
            r_o_fin  <= 1'b1;
        end
    end

    assign o_stat.div_busy = div_busy;
    assign o_stat.div_done = div_done;
    assign o_stat.x_lt_y   = (r_pos_x < r_pos_y);
    assign o_stat.idx_last = (r_idx == ddacg_pkg::SYM_LAST);
    assign o_stat.out_free = out_free;

    assign o_valid       = r_o_valid;
    assign o_point_x     = r_o_px;
    assign o_point_y     = r_o_py;
    assign o_point_valid = r_o_pv;
    assign o_last        = r_o_last;
    assign o_finished    = r_o_fin;

endmodule

### sv/ddacg_ctrl.sv
// sequencing state machine of the dda circle generator
module ddacg_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic             i_cmd,
    output logic             o_stall,
    input  ddacg_pkg::t_stat i_stat,
    output ddacg_pkg::t_cmd  o_cmd
);

    ddacg_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ddacg_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_stall = 1'b1;
        unique case (r_state)
            ddacg_pkg::S_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    if (i_cmd == ddacg_pkg::CMD_START) begin
                        o_cmd.load_start = 1'b1;
                        n_state = ddacg_pkg::S_DIV;
                    end else if (i_stat.x_lt_y) begin
                        n_state = ddacg_pkg::S_INVALID;
                    end else begin
                        o_cmd.mul_y = 1'b1;
                        n_state = ddacg_pkg::S_MUL_X;
                    end
                end
            end
            ddacg_pkg::S_DIV: begin
                if (i_stat.div_done) begin
                    o_cmd.store_inc = 1'b1;
                    n_state = ddacg_pkg::S_IDLE;
                end
            end
            ddacg_pkg::S_MUL_X: begin
                o_cmd.mul_x = 1'b1;
                n_state = ddacg_pkg::S_UPD;
            end
            ddacg_pkg::S_UPD: begin
                o_cmd.update = 1'b1;
                n_state = ddacg_pkg::S_EMIT;
            end
            ddacg_pkg::S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_point = 1'b1;
                    if (i_stat.idx_last) begin
                        n_state = ddacg_pkg::S_IDLE;
                    end
                end
            end
            ddacg_pkg::S_INVALID: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_invalid = 1'b1;
                    n_state = ddacg_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ddacg_pkg::S_IDLE;
            end
        endcase
    end

endmodule

### sv/dda_circle_generator.sv
// top level of the dda circle generator: controller, datapath and checks
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+----------------------------------------
//  input   | in        | i_valid / o_stall  | i_cmd, i_center_x, i_center_y, i_radius
//  result  | out       | o_valid / i_stall  | o_point_x, o_point_y, o_point_valid,
//          |           |                    | o_last, o_finished
//
// a step transaction uses the shared multiplier for y*inc and then x*inc, makes one
//   position update and emits eight points through the result register
// a start transaction runs the one bit per cycle divider forming 1/r; a step after
//   the circle is done gives a single invalid result
// synchronous active-low reset clears the state machine, the positions and the
//   increment; no clearing pass is needed
// a stalled result holds in the output register and the emit sequence waits on it;
//   the input side is stalled whenever the controller is not idle
module dda_circle_generator (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic                                i_cmd,
    input  logic [ddacg_pkg::CX_W-1:0]          i_center_x,
    input  logic [ddacg_pkg::CX_W-1:0]          i_center_y,
    input  logic [ddacg_pkg::RAD_W-1:0]         i_radius,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [ddacg_pkg::PIX_W-1:0]  o_point_x,
    output logic signed [ddacg_pkg::PIX_W-1:0]  o_point_y,
    output logic                                o_point_valid,
    output logic                                o_last,
    output logic                                o_finished
);

    // command and status between the sequencer and the datapath
    ddacg_pkg::t_cmd  cmd;
    ddacg_pkg::t_stat stat;

    // sequencer: decodes the transaction and walks divide, multiply, update and emit or the invalid result
    ddacg_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_cmd   (i_cmd),
        .o_stall (o_stall),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // datapath: divider, shared multiplier, positions and the result register
    ddacg_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_center_x    (i_center_x),
        .i_center_y    (i_center_y),
        .i_radius      (i_radius),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_point_x     (o_point_x),
        .o_point_y     (o_point_y),
        .o_point_valid (o_point_valid),
        .o_last        (o_last),
        .o_finished    (o_finished)
    );

    // the input is only taken once the divider has finished
    a_no_accept_while_dividing : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        !o_stall |-> !stat.div_busy
    ) else $error("input open while divider busy");

    // a result is only loaded when the output register can take it
    a_load_only_when_free : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (cmd.emit_point || cmd.emit_invalid) |-> stat.out_free
    ) else $error("result register overwritten");

    // an invalid result is always the closing, finished one at the origin
    a_invalid_shape : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_point_valid) |->
            (o_last && o_finished && o_point_x == '0 && o_point_y == '0)
    ) else $error("malformed invalid result");

    // a new transaction is never taken while a point sequence is still running
    a_emit_completes : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (cmd.emit_point && !stat.idx_last) |=> o_stall
    ) else $error("input opened mid sequence");

endmodule

### test/dda_circle_checker.sv
// checker for the dda circle generator: watches both channels, predicts the points and compares
`timescale 1ns / 100ps

module dda_circle_checker
    import ddacg_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    input  logic                    i_in_stall,
    input  logic                    i_cmd,
    input  logic [CX_W-1:0]         i_center_x,
    input  logic [CX_W-1:0]         i_center_y,
    input  logic [RAD_W-1:0]        i_radius,
    input  logic                    i_out_valid,
    input  logic                    i_out_stall,
    input  logic signed [PIX_W-1:0] i_point_x,
    input  logic signed [PIX_W-1:0] i_point_y,
    input  logic                    i_point_valid,
    input  logic                    i_last,
    input  logic                    i_finished,
    output int                      o_mismatches,
    output int                      o_pending
);

    typedef struct {
        logic signed [PIX_W-1:0] px;
        logic signed [PIX_W-1:0] py;
        logic                    real_pt;
        logic                    last;
        logic                    done;
    } t_pixel_result;

    t_pixel_result awaited_points[$];

    // own copy of the circle state
    logic [CX_W-1:0]            hub_x;
    logic [CX_W-1:0]            hub_y;
    logic [STEP_BITS-1:0]       step_inc;
    logic signed [POS_BITS-1:0] arc_x;
    logic signed [POS_BITS-1:0] arc_y;

    task automatic note_mismatch(input string msg);
        o_mismatches++;
        $display("%0t mismatch: %s", $time, msg);
    endtask

    // v * inc / 2^STEP_BITS, truncated toward zero
    function automatic longint scale_by_inc(input longint v);
        logic [63:0] mag;
        logic [63:0] prod;
        mag  = (v < 0) ? 64'(-v) : 64'(v);
        prod = (mag * 64'(step_inc)) >> STEP_BITS;
        return (v < 0) ? -longint'(prod) : longint'(prod);
    endfunction

    function automatic logic signed [POS_BITS-1:0] clamp_pos(input longint v);
        if (v > longint'(POS_MAX))
            return POS_MAX;
        if (v < longint'(POS_MIN))
            return POS_MIN;
        return POS_BITS'(v);
    endfunction

    // centre plus offset, truncated toward zero and clamped to the pixel range
    function automatic logic signed [PIX_W-1:0] pixel_of(input logic [CX_W-1:0] c,
                                                         input longint off);
        longint s;
        longint p;
        s = (longint'(c) <<< FRAC_BITS) + off;
        p = (s >= 0) ? (s >>> FRAC_BITS) : -((-s) >>> FRAC_BITS);
        if (p > longint'(PIX_MAX))
            p = longint'(PIX_MAX);
        if (p < longint'(PIX_MIN))
            p = longint'(PIX_MIN);
        return PIX_W'(p);
    endfunction

    task automatic load_circle();
        logic [63:0] r;
        logic [63:0] q;
        r = (i_radius == '0) ? 64'd1 : 64'(i_radius);
        q = (64'd1 << STEP_BITS) / r;
        if (q > (64'd1 << STEP_BITS) - 1)
            q = (64'd1 << STEP_BITS) - 1;
        hub_x    = i_center_x;
        hub_y    = i_center_y;
        step_inc = STEP_BITS'(q);
        arc_x    = POS_BITS'(r << FRAC_BITS);
        arc_y    = '0;
    endtask

    task automatic advance_circle();
        t_pixel_result pt;
        longint        x0;
        longint        y0;
        longint        x;
        longint        y;
        longint        ox[8];
        longint        oy[8];
        logic          done;
        if (arc_x < arc_y) begin
            // circle already complete: one empty result, state kept
            pt = '{px: '0, py: '0, real_pt: 1'b0, last: 1'b1, done: 1'b1};
            awaited_points.push_back(pt);
            return;
        end
        x0    = longint'(arc_x);
        y0    = longint'(arc_y);
        arc_x = clamp_pos(x0 - scale_by_inc(y0));
        arc_y = clamp_pos(y0 + scale_by_inc(x0));
        done  = arc_x < arc_y;
        x     = longint'(arc_x);
        y     = longint'(arc_y);
        ox    = '{x, y, -x, y, -x, -y, x, -y};
        oy    = '{y, x, y, -x, -y, -x, -y, x};
        for (int k = 0; k < 8; k++) begin
            pt.px      = pixel_of(hub_x, ox[k]);
            pt.py      = pixel_of(hub_y, oy[k]);
            pt.real_pt = 1'b1;
            pt.last    = (k == 7);
            pt.done    = done;
            awaited_points.push_back(pt);
        end
    endtask

    task automatic check_point();
        t_pixel_result want;
        if (awaited_points.size() == 0) begin
            note_mismatch($sformatf("result with nothing expected (x %0d y %0d)",
                                    i_point_x, i_point_y));
            return;
        end
        want = awaited_points.pop_front();
        if (i_point_x !== want.px)
            note_mismatch($sformatf("point_x %0d, expected %0d", i_point_x, want.px));
        if (i_point_y !== want.py)
            note_mismatch($sformatf("point_y %0d, expected %0d", i_point_y, want.py));
        if (i_point_valid !== want.real_pt)
            note_mismatch($sformatf("point_valid %b, expected %b", i_point_valid,
                                    want.real_pt));
        if (i_last !== want.last)
            note_mismatch($sformatf("last %b, expected %b", i_last, want.last));
        if (i_finished !== want.done)
            note_mismatch($sformatf("finished %b, expected %b", i_finished, want.done));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hub_x    = '0;
            hub_y    = '0;
            step_inc = '0;
            arc_x    = '0;
            arc_y    = '0;
            awaited_points.delete();
        end else begin
            if (i_out_valid && !i_out_stall)
                check_point();
            if (i_in_valid && !i_in_stall) begin
                if (i_cmd == CMD_START)
                    load_circle();
                else
                    advance_circle();
            end
        end
        o_pending = awaited_points.size();
    end

endmodule

### test/dda_circle_generator_tb.sv
// testbench top of the dda circle generator: clock, reset, stimulus and verdict
`timescale 1ns / 100ps

module dda_circle_generator_tb;
    import ddacg_pkg::*;

    localparam int HALF_PERIOD   = 5;
    localparam int RESET_CYCLES  = 8;
    localparam int RANDOM_ITEMS  = 345;
    localparam int MAX_IDLE      = 10;
    localparam int LONG_HOLD     = 300;    // receiver hold-off, long enough to back up the input
    localparam int SETTLE_CYCLES = 40;     // wait after draining, longer than a start transaction
    localparam int DRAIN_LIMIT   = 200000;
    localparam int TIMEOUT_NS    = 4000000;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_valid;
    logic                    o_stall;
    logic                    i_cmd;
    logic [CX_W-1:0]         i_center_x;
    logic [CX_W-1:0]         i_center_y;
    logic [RAD_W-1:0]        i_radius;
    logic                    o_valid;
    logic                    i_stall;
    logic signed [PIX_W-1:0] o_point_x;
    logic signed [PIX_W-1:0] o_point_y;
    logic                    o_point_valid;
    logic                    o_last;
    logic                    o_finished;

    int mismatches;
    int points_pending;

    // shared between the sender and the receiver process
    bit hold_long;    // receiver takes one long hold-off at its next draw
    bit no_idle;      // both sides run flat out while set

    dda_circle_generator u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_cmd         (i_cmd),
        .i_center_x    (i_center_x),
        .i_center_y    (i_center_y),
        .i_radius      (i_radius),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_point_x     (o_point_x),
        .o_point_y     (o_point_y),
        .o_point_valid (o_point_valid),
        .o_last        (o_last),
        .o_finished    (o_finished)
    );

    dda_circle_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_valid),
        .i_in_stall    (o_stall),
        .i_cmd         (i_cmd),
        .i_center_x    (i_center_x),
        .i_center_y    (i_center_y),
        .i_radius      (i_radius),
        .i_out_valid   (o_valid),
        .i_out_stall   (i_stall),
        .i_point_x     (o_point_x),
        .i_point_y     (o_point_y),
        .i_point_valid (o_point_valid),
        .i_last        (o_last),
        .i_finished    (o_finished),
        .o_mismatches  (mismatches),
        .o_pending     (points_pending)
    );

    // free-running clock, 10 ns period
    initial i_clk = 1'b0;
    always #HALF_PERIOD i_clk = ~i_clk;

    // hard stop in case the block hangs or loses a transaction
    initial begin
        #(TIMEOUT_NS);
        $display("dda_circle_generator_tb NOT OK");
        $finish;
    end

    // offer one transaction after a random gap and hold it until the block takes it;
    // valid stays high across back-to-back transactions so it never toggles within a step
    task automatic send_item(input logic cmd, input logic [CX_W-1:0] cx,
                             input logic [CX_W-1:0] cy, input logic [RAD_W-1:0] rad);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_cmd      = cmd;
        i_center_x = cx;
        i_center_y = cy;
        i_radius   = rad;
        i_valid    = 1'b1;
        do @(posedge i_clk); while (o_stall);
    endtask

    // a step transaction ignores the centre and radius, so those bits are just noise
    task automatic send_step();
        send_item(CMD_STEP, CX_W'($urandom), CX_W'($urandom), RAD_W'($urandom));
    endtask

    task automatic send_steps(input int n);
        repeat (n) send_step();
    endtask

    // sender goes quiet until every predicted point has come out
    task automatic wait_drained();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (points_pending != 0) @(negedge i_clk);
    endtask

    // result side: per result draw a random hold-off of 0..MAX_IDLE, then accept;
    // a long hold-off is taken once on request from the stimulus
    initial begin
        int hold;
        i_stall = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            hold = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
            if (hold_long) begin
                hold      = LONG_HOLD;
                hold_long = 1'b0;
            end
            @(negedge i_clk);
            if (hold != 0) begin
                i_stall = 1'b1;
                repeat (hold) @(negedge i_clk);
            end
            i_stall = 1'b0;
            do @(posedge i_clk); while (o_valid !== 1'b1);
        end
    end

    // stimulus and verdict
    initial begin
        int              random_sent;
        int              kind;
        int              steps;
        int              waited;
        bit              held;
        bit              paused;
        logic [CX_W-1:0] cx;
        logic [CX_W-1:0] cy;
        logic [RAD_W-1:0] rad;

        random_sent = 0;
        held        = 1'b0;
        paused      = 1'b0;
        hold_long   = 1'b0;
        no_idle     = 1'b0;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_cmd       = CMD_START;
        i_center_x  = '0;
        i_center_y  = '0;
        i_radius    = '0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;

        // ---- directed part ----
        // steps straight out of reset: zero position and zero increment, points at the origin
        send_steps(2);
        // radius one with the centre at the origin: increment saturates, negative offsets
        // truncate toward zero; third step lands on an already finished circle
        send_item(CMD_START, '0, '0, RAD_W'(1));
        send_steps(3);
        // largest centre and radius
        send_item(CMD_START, CX_W'(2047), CX_W'(2047), RAD_W'(1023));
        send_steps(2);
        // zero radius behaves as radius one
        send_item(CMD_START, CX_W'(1234), CX_W'(813), '0);
        send_steps(3);
        // alternating bit patterns on all start fields
        send_item(CMD_START, CX_W'(11'h555), CX_W'(11'h2aa), RAD_W'(10'h2aa));
        send_steps(2);
        // small circle run past completion, mixed extreme centre
        send_item(CMD_START, '0, CX_W'(2047), RAD_W'(3));
        send_steps(5);
        wait_drained();

        // ---- random part ----
        // mostly whole circles with small radii so they reach completion; a few large
        // radii run only a short arc; some circles are cut short by a new start, and
        // a share of transactions is plain noise
        while (random_sent < RANDOM_ITEMS) begin
            if (!held && random_sent >= 100) begin
                hold_long = 1'b1;
                held      = 1'b1;
            end
            if (!paused && random_sent >= 200) begin
                wait_drained();
                paused = 1'b1;
            end
            no_idle = (random_sent >= 250 && random_sent < 300);

            kind = $urandom_range(0, 9);
            if (kind == 0) begin
                send_item(1'($urandom), CX_W'($urandom), CX_W'($urandom), RAD_W'($urandom));
                random_sent++;
            end else begin
                cx = CX_W'($urandom_range(0, 2047));
                cy = CX_W'($urandom_range(0, 2047));
                if (kind == 1) begin
                    rad   = RAD_W'($urandom_range(25, 1023));
                    steps = $urandom_range(4, 24);
                end else begin
                    rad   = RAD_W'($urandom_range(1, 24));
                    steps = rad + $urandom_range(0, 3);
                end
                if ($urandom_range(0, 5) == 0)
                    steps = $urandom_range(0, steps);
                send_item(CMD_START, cx, cy, rad);
                send_steps(steps);
                random_sent += steps + 1;
            end
        end
        no_idle = 1'b0;

        // ---- wind down ----
        @(negedge i_clk);
        i_valid = 1'b0;
        waited  = 0;
        while (points_pending != 0 && waited < DRAIN_LIMIT) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && points_pending == 0)
            $display("dda_circle_generator_tb OK");
        else
            $display("dda_circle_generator_tb NOT OK");
        $finish;
    end

endmodule
